// ----- hw/rtl/smf_pkg.sv -----
package smf_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROBE = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic REG_KEEP_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic en;
  } cmp_ctl_t;

endpackage

// ----- hw/rtl/smf_item_if.sv -----
interface smf_item_if;
  import smf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

// ----- hw/rtl/smf_result_if.sv -----
interface smf_result_if;
  import smf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] kept_value;
  logic [POS_W-1:0]          probe_position;
  logic                      set_overflow;

  modport source (output valid, kept_value, probe_position, set_overflow, input ready);
  modport sink   (input valid, kept_value, probe_position, set_overflow, output ready);
endinterface

// ----- hw/rtl/smf_ram.sv -----
module smf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/smf_cmp.sv -----
module smf_cmp (
  input  logic                       clk,
  input  logic                       rst,
  input  smf_pkg::cmp_ctl_t          ctl,
  input  logic [smf_pkg::VALUE_W-1:0] entry,
  input  logic [smf_pkg::VALUE_W-1:0] probe,
  output logic                       hit
);
  import smf_pkg::*;

  // sticky match over the scan, cleared when a new probe starts
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.start) begin
      hit <= 1'b0;
    end else if (ctl.en && (entry == probe)) begin
      hit <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/smf_seq.sv -----
module smf_seq #(
  parameter int SET_DEPTH = 64,
  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
  localparam int CW = $clog2(SET_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        keep_mode,
  smf_item_if.sink                    item,
  smf_result_if.source                result,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [smf_pkg::VALUE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output smf_pkg::cmp_ctl_t           cmp_ctl,
  output logic [smf_pkg::VALUE_W-1:0] probe,
  input  logic                        hit
);
  import smf_pkg::*;

  seq_state_t        state;
  logic [CW-1:0]     ref_count;
  logic [POS_W-1:0]  probe_counter;
  logic              overflow;
  logic [POS_W-1:0]  probe_pos;
  logic [AW-1:0]     scan_addr;
  logic              issue_on;
  logic              cmp_valid;
  logic              cmp_last;
  logic              out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]  out_pos;
  logic              out_ovf;

  logic              accept;
  logic              start_probe;
  logic              not_full;
  logic [AW-1:0]     last_addr;
  logic              keep;
  logic              out_free;
  logic              out_load;

  assign item.ready  = (state == ST_IDLE);
  assign accept      = item.valid && item.ready;
  assign start_probe = accept && (item.kind == KIND_PROBE);
  assign not_full    = (ref_count < CW'(SET_DEPTH));
  assign last_addr   = AW'(ref_count - CW'(1));

  assign wr_en   = accept && (item.kind == KIND_LOAD) && not_full;
  assign wr_addr = ref_count[AW-1:0];
  assign wr_data = item.value;

  assign rd_en   = (state == ST_SCAN) && issue_on;
  assign rd_addr = scan_addr;

  assign cmp_ctl.start = start_probe;
  assign cmp_ctl.en    = cmp_valid;

  assign keep     = keep_mode ? !hit : hit;
  assign out_free = !out_valid || result.ready;
  assign out_load = (state == ST_DONE) && keep && out_free;

  assign result.valid          = out_valid;
  assign result.kept_value     = out_value;
  assign result.probe_position = out_pos;
  assign result.set_overflow   = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ref_count     <= '0;
      probe_counter <= '0;
      overflow      <= 1'b0;
      scan_addr     <= '0;
      issue_on      <= 1'b0;
      cmp_valid     <= 1'b0;
      cmp_last      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.kind)
              KIND_CLEAR: begin
                ref_count     <= '0;
                probe_counter <= '0;
                overflow      <= 1'b0;
              end
              KIND_LOAD: begin
                if (not_full) begin
                  ref_count <= ref_count + CW'(1);
                end else begin
                  overflow <= 1'b1;
                end
              end
              KIND_PROBE: begin
                if (probe_counter != POS_MAX) begin
                  probe_counter <= probe_counter + POS_W'(1);
                end
                scan_addr <= '0;
                issue_on  <= (ref_count != '0);
                // empty set: nothing to scan, hit stays clear
                state     <= (ref_count != '0) ? ST_SCAN : ST_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // read data is registered, so it arrives in the cycle after its address
          cmp_valid <= issue_on;
          cmp_last  <= (scan_addr == last_addr);
          if (issue_on) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == last_addr) begin
              issue_on <= 1'b0;
            end
          end
          if (cmp_valid && cmp_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!keep || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_probe) begin
      probe     <= item.value;
      probe_pos <= probe_counter;
    end
    if (out_load) begin
      out_value <= probe;
      out_pos   <= probe_pos;
      out_ovf   <= overflow;
    end
  end

endmodule

// ----- hw/rtl/set_membership_filter.sv -----
// channel   dir  handshake      payload
// item      in   valid/ready    kind, value
// result    out  valid/ready    kept_value, probe_position, set_overflow
// apb       in   psel/penable   keep_mode at byte address 0
//
// clear and load complete when accepted; a probe scans the N loaded entries
// (an empty set skips the scan), one stored entry read and compared per cycle
// through the single read port of the reference memory
// reset clears counts and flags; the reference memory holds no reset value
// a kept probe waits in its final state while the result register is full

module set_membership_filter #(
  parameter int SET_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  smf_item_if.sink      item,
  smf_result_if.source  result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import smf_pkg::*;

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  logic               keep_mode;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  cmp_ctl_t           cmp_ctl;
  logic [VALUE_W-1:0] probe;
  logic               hit;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_KEEP_MODE);
  assign prdata  = reg_sel ? {31'b0, keep_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      keep_mode <= pwdata[0];
    end
  end

  smf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SET_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smf_cmp u_cmp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cmp_ctl),
    .entry (rd_data),
    .probe (probe),
    .hit   (hit)
  );

  smf_seq #(
    .SET_DEPTH (SET_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .keep_mode (keep_mode),
    .item      (item),
    .result    (result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .cmp_ctl   (cmp_ctl),
    .probe     (probe),
    .hit       (hit)
  );

  a_wr_only_on_load: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (item.valid && item.ready && item.kind == KIND_LOAD))
    else $error("memory write without an accepted load request");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("memory read and write in the same cycle");

  a_busy_during_scan: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !item.ready)
    else $error("request taken while the set is being scanned");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    cmp_ctl.en |-> $past(rd_en))
    else $error("compare without a read issued the cycle before");

endmodule
